// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros: assertion helper macros
// Shared concurrent assertion forms used by the controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication check, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Commands, status codes, controller states and the control word types.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int WIDTH  = 32;
   localparam int MAG_W  = 2 * WIDTH;
   localparam int CNT_W  = $clog2(MAG_W + 1);

   // first magnitude outside the positive operand range
   localparam logic [MAG_W-1:0] LIM = MAG_W'(1) << (WIDTH - 1);

   typedef enum logic [2:0] {
      CMD_ADD = 3'd0, CMD_SUB = 3'd1, CMD_MUL = 3'd2, CMD_DIV = 3'd3,
      CMD_NEG = 3'd4, CMD_RED = 3'd5, CMD_CMP = 3'd6, CMD_NOP = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_ZERO_DEN = 2'd1, ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ORD_LESS = 2'd0, ORD_EQUAL = 2'd1, ORD_GREATER = 2'd2
   } order_type;

   typedef enum logic [3:0] {
      S_IDLE, S_PROD, S_COMB, S_GCD_START, S_GCD_DIV, S_GCD_NEXT,
      S_QN_START, S_QN_DIV, S_QD_START, S_QD_DIV, S_FINISH, S_DONE
   } state_type;

   // op selects what the datapath does this cycle
   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_PROD, OP_COMB, OP_GCD_INIT, OP_DIV_STEP,
      OP_GCD_SWAP, OP_QN_INIT, OP_QN_SAVE, OP_QD_INIT, OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
   } ctrl_type;

   typedef struct packed {
      logic early;     // result decided at load (error, nop)
      logic is_cmp;
      logic div_done;
      logic rem_zero;  // divisor of next gcd step is zero
   } stat_type;

endpackage

// ----- hdl/rational_arithmetic_unit.sv -----
// Sequence: nop and zero-denominator words finish right after load, compare
// words after the combine step; all others run the gcd remainder steps and
// then the two exact quotients, one quotient bit per cycle in the shared 64-bit
// restoring divider.
// Throughput: one word at a time; busy is high until the result strobe ends.
// Reset: synchronous active-high reset returns the controller to idle.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: exact fraction arithmetic with gcd reduction
// Controller plus datapath; results reduced to lowest terms.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_x_num,
   input  logic [31:0] req_x_den,
   input  logic [31:0] req_y_num,
   input  logic [31:0] req_y_den,
   output logic        rsp_valid,
   output logic [31:0] rsp_res_num,
   output logic [30:0] rsp_res_den,
   output logic [1:0]  rsp_order,
   output logic [1:0]  rsp_status
);

   ctrl_type ctrl;
   stat_type stat;

   rau_ctrl u_ctrl (
      .clock (clock), .reset (reset), .start (start), .busy (busy),
      .done  (rsp_valid), .ctrl (ctrl), .stat (stat)
   );

   rau_dp u_dp (
      .clock   (clock), .ctrl (ctrl), .stat (stat),
      .cmd_i   (req_command), .xn_i (req_x_num), .xd_i (req_x_den),
      .yn_i    (req_y_num), .yd_i (req_y_den),
      .res_num (rsp_res_num), .res_den (rsp_res_den),
      .order   (rsp_order), .status (rsp_status)
   );

endmodule

// ----- hdl/rau_ctrl.sv -----
// ----------------------------------------------------------------------------
// rau_ctrl: sequencing controller
// Walks the product, combine, gcd and quotient phases of one word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rau_ctrl import rau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   output logic     done,
   output ctrl_type ctrl,
   input  stat_type stat
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ctrl.op  = OP_NONE;
      busy     = (state_ff != S_IDLE);
      done     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctrl.op  = OP_LOAD;
               state_in = S_PROD;
            end
         end
         S_PROD: begin
            if (stat.early) state_in = S_DONE;
            else begin
               ctrl.op  = OP_PROD;
               state_in = S_COMB;
            end
         end
         S_COMB: begin
            ctrl.op  = OP_COMB;
            state_in = stat.is_cmp ? S_DONE : S_GCD_START;
         end
         S_GCD_START: begin
            ctrl.op  = OP_GCD_INIT;
            state_in = stat.rem_zero ? S_QN_START : S_GCD_DIV;
         end
         S_GCD_DIV: begin
            ctrl.op = OP_DIV_STEP;
            if (stat.div_done) state_in = S_GCD_NEXT;
         end
         S_GCD_NEXT: begin
            ctrl.op  = OP_GCD_SWAP;
            state_in = stat.rem_zero ? S_QN_START : S_GCD_DIV;
         end
         S_QN_START: begin
            ctrl.op  = OP_QN_INIT;
            state_in = S_QN_DIV;
         end
         S_QN_DIV: begin
            ctrl.op = OP_DIV_STEP;
            if (stat.div_done) state_in = S_QD_START;
         end
         S_QD_START: begin
            ctrl.op  = OP_QD_INIT;
            state_in = S_QD_DIV;
         end
         S_QD_DIV: begin
            ctrl.op = OP_DIV_STEP;
            if (stat.div_done) state_in = S_FINISH;
         end
         S_FINISH: begin
            ctrl.op  = OP_FINISH;
            state_in = S_DONE;
         end
         S_DONE: begin
            done     = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   `ASSERT_NEXT(a_done_to_idle, clock, reset, done, state_ff == S_IDLE, "done not followed by idle")
   `ASSERT_IMPL(a_busy_no_load, clock, reset, busy, ctrl.op != OP_LOAD, "load while busy")
   `ASSERT_IMPL(a_start_loads, clock, reset, start && !busy, ctrl.op == OP_LOAD, "start not loaded")

endmodule

// ----- hdl/rau_dp.sv -----
// ----------------------------------------------------------------------------
// rau_dp: datapath
// Operand decode, cross products, signed combine, shared restoring divider
// used for gcd remainders and the two exact quotients, range check.
// ----------------------------------------------------------------------------
module rau_dp import rau_pkg::*; (
   input  logic              clock,
   input  ctrl_type          ctrl,
   output stat_type          stat,
   input  logic [2:0]        cmd_i,
   input  logic [31:0]       xn_i,
   input  logic [31:0]       xd_i,
   input  logic [31:0]       yn_i,
   input  logic [31:0]       yd_i,
   output logic [31:0]       res_num,
   output logic [30:0]       res_den,
   output logic [1:0]        order,
   output logic [1:0]        status
);

   // operand magnitudes and signs
   logic [WIDTH-1:0] xn_m_ff, xd_m_ff, yn_m_ff, yd_m_ff;
   logic             xn_s_ff, yn_s_ff;
   cmd_type          cmd_ff;
   logic             early_ff;
   // products
   logic [MAG_W-1:0] p1_ff, p2_ff, pd_ff;
   logic             p1_s_ff, p2_s_ff;
   // reduced candidate
   logic [MAG_W-1:0] n_ff, d_ff;
   logic             n_s_ff;
   // divider
   logic [MAG_W-1:0] a_ff, b_ff, r_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [MAG_W-1:0] g_ff;
   // result
   logic [31:0]      rn_ff;
   logic [30:0]      rd_ff;
   logic [1:0]       ord_ff, st_ff;

   logic [WIDTH-1:0] xn_w, xd_w, yn_w, yd_w;
   logic [WIDTH-1:0] xn_m, xd_m, yn_m, yd_m;
   logic             xn_s, xd_s, yn_s, yd_s, uses_y;
   logic             zero_den;
   logic [WIDTH-1:0] m1_b, md_b;
   logic             p1_s_in, p2_en;
   logic [MAG_W:0]   rtry;
   logic [MAG_W-1:0] rsh;
   logic [MAG_W-1:0] diff_m;
   logic             diff_s;
   logic             a2_s;

   // operand decode
   always_comb begin
      xn_w = xn_i[WIDTH-1:0];
      xd_w = xd_i[WIDTH-1:0];
      yn_w = yn_i[WIDTH-1:0];
      yd_w = yd_i[WIDTH-1:0];
      xn_s = xn_w[WIDTH-1];
      xd_s = xd_w[WIDTH-1];
      yn_s = yn_w[WIDTH-1];
      yd_s = yd_w[WIDTH-1];
      xn_m = xn_s ? (~xn_w + 1'b1) : xn_w;
      xd_m = xd_s ? (~xd_w + 1'b1) : xd_w;
      yn_m = yn_s ? (~yn_w + 1'b1) : yn_w;
      yd_m = yd_s ? (~yd_w + 1'b1) : yd_w;
      uses_y = (cmd_i <= 3'(CMD_DIV)) || (cmd_i == 3'(CMD_CMP));
      zero_den = (cmd_i != 3'(CMD_NOP)) &&
                 (xd_m == '0 || (uses_y && yd_m == '0) ||
                  (cmd_i == 3'(CMD_DIV) && yn_m == '0));
   end

   // product operand select: p1 = xn * m1_b, pd = xd * md_b
   always_comb begin
      m1_b    = yd_m_ff;
      md_b    = yd_m_ff;
      p1_s_in = xn_s_ff;
      p2_en   = 1'b0;
      case (cmd_ff)
         CMD_MUL: begin
            m1_b    = yn_m_ff;
            p1_s_in = xn_s_ff ^ yn_s_ff;
         end
         CMD_DIV: begin
            md_b    = yn_m_ff;
            p1_s_in = xn_s_ff ^ yn_s_ff;
         end
         CMD_NEG: begin
            m1_b    = WIDTH'(1);
            md_b    = WIDTH'(1);
            p1_s_in = ~xn_s_ff;
         end
         CMD_RED: begin
            m1_b = WIDTH'(1);
            md_b = WIDTH'(1);
         end
         default: p2_en = 1'b1;
      endcase
   end

   // combine p1 (+/-) p2, sign of p2 flipped for sub and compare
   always_comb begin
      a2_s = p2_s_ff ^ ((cmd_ff == CMD_SUB) || (cmd_ff == CMD_CMP));
      if (p2_ff == '0) a2_s = 1'b0;
      if (p1_s_ff == a2_s) begin
         diff_m = p1_ff + p2_ff;
         diff_s = p1_s_ff;
      end else if (p1_ff >= p2_ff) begin
         diff_m = p1_ff - p2_ff;
         diff_s = p1_s_ff;
      end else begin
         diff_m = p2_ff - p1_ff;
         diff_s = a2_s;
      end
      if (diff_m == '0) diff_s = 1'b0;
   end

   // one restoring divider step: a_ff shifts out into r
   always_comb begin
      rsh  = {r_ff[MAG_W-2:0], a_ff[MAG_W-1]};
      rtry = {r_ff, a_ff[MAG_W-1]} - {1'b0, b_ff};
   end

   assign stat.early    = early_ff;
   assign stat.is_cmp   = (cmd_ff == CMD_CMP);
   assign stat.div_done = (cnt_ff == CNT_W'(MAG_W - 1));
   assign stat.rem_zero = (ctrl.op == OP_GCD_INIT) ? (d_ff == '0) : (r_ff == '0);

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (ctrl.op)
         OP_LOAD: begin
            cmd_ff   <= cmd_type'(cmd_i);
            xn_m_ff  <= xn_m;
            xd_m_ff  <= xd_m;
            yn_m_ff  <= yn_m;
            yd_m_ff  <= yd_m;
            xn_s_ff  <= (xn_s ^ xd_s) && (xn_m != '0);
            yn_s_ff  <= (yn_s ^ yd_s) && (yn_m != '0);
            // nop and zero denominators finish right after load
            early_ff <= (cmd_i == 3'(CMD_NOP)) || zero_den;
            rn_ff    <= '0;
            rd_ff    <= zero_den ? 31'd0 : 31'd1;
            ord_ff   <= ORD_LESS;
            st_ff    <= zero_den ? ST_ZERO_DEN : ST_OK;
         end
         OP_PROD: begin
            p1_ff   <= MAG_W'(xn_m_ff) * MAG_W'(m1_b);
            p2_ff   <= p2_en ? MAG_W'(yn_m_ff) * MAG_W'(xd_m_ff) : '0;
            pd_ff   <= MAG_W'(xd_m_ff) * MAG_W'(md_b);
            p1_s_ff <= p1_s_in;
            p2_s_ff <= yn_s_ff;
         end
         OP_COMB: begin
            n_ff   <= diff_m;
            n_s_ff <= diff_s;
            d_ff   <= pd_ff;
            if (cmd_ff != CMD_CMP) ord_ff <= ORD_LESS;
            else if (diff_m == '0) ord_ff <= ORD_EQUAL;
            else if (diff_s)       ord_ff <= ORD_LESS;
            else                   ord_ff <= ORD_GREATER;
         end
         OP_GCD_INIT: begin
            // gcd(n, d): dividend n, divisor d; d is nonzero here
            a_ff   <= n_ff;
            b_ff   <= d_ff;
            g_ff   <= d_ff;
            r_ff   <= '0;
            cnt_ff <= '0;
         end
         OP_DIV_STEP: begin
            a_ff   <= {a_ff[MAG_W-2:0], ~rtry[MAG_W]};
            r_ff   <= rtry[MAG_W] ? rsh : rtry[MAG_W-1:0];
            cnt_ff <= cnt_ff + 1'b1;
         end
         OP_GCD_SWAP: begin
            // old divisor becomes dividend, remainder the divisor
            a_ff   <= b_ff;
            b_ff   <= r_ff;
            g_ff   <= (r_ff == '0) ? b_ff : r_ff;
            r_ff   <= '0;
            cnt_ff <= '0;
         end
         OP_QN_INIT: begin
            a_ff   <= n_ff;
            b_ff   <= g_ff;
            r_ff   <= '0;
            cnt_ff <= '0;
         end
         OP_QD_INIT: begin
            n_ff   <= a_ff;
            a_ff   <= d_ff;
            b_ff   <= g_ff;
            r_ff   <= '0;
            cnt_ff <= '0;
         end
         OP_FINISH: begin
            if (n_ff == '0) begin
               rn_ff <= '0;
               rd_ff <= 31'd1;
            end else if ((n_s_ff ? (n_ff > LIM) : (n_ff > LIM - 1'b1)) ||
                         (a_ff > LIM - 1'b1)) begin
               st_ff <= ST_OVERFLOW;
               rn_ff <= '0;
               rd_ff <= '0;
            end else begin
               rn_ff <= n_s_ff ? 32'(-n_ff) : n_ff[31:0];
               rd_ff <= a_ff[30:0];
            end
         end
         default: ;
      endcase
   end

   assign res_num = rn_ff;
   assign res_den = rd_ff;
   assign order   = (st_ff != ST_OK) ? 2'(ORD_LESS) : ord_ff;
   assign status  = st_ff;

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the rational arithmetic unit
// Directed corner words, then random fraction words with idle gaps; every
// result strobe is checked against an exact predictor of the reduced result.
// ----------------------------------------------------------------------------
module tb;
   import rau_pkg::*;

   typedef struct {
      cmd_type     command;
      logic [31:0] x_num, x_den, y_num, y_den;
   } word_type;

   typedef struct {
      logic [31:0] res_num;
      logic [30:0] res_den;
      logic [1:0]  order;
      logic [1:0]  status;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_command = '0;
   logic [31:0] req_x_num = '0, req_x_den = '0, req_y_num = '0, req_y_den = '0;
   logic        rsp_valid;
   logic [31:0] rsp_res_num;
   logic [30:0] rsp_res_den;
   logic [1:0]  rsp_order;
   logic [1:0]  rsp_status;

   word_type   pending_words[$];
   answer_type expected_answers[$];
   int         mismatches = 0;
   int         words_sent = 0;
   int         words_total = 0;
   int         answers_seen = 0;
   int         gap_left = 0;

   rational_arithmetic_unit DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // signed 64-bit magnitude with a sign, formed exactly
   typedef struct {
      bit          neg;
      logic [63:0] mag;
   } signed_mag_type;

   function automatic signed_mag_type split_sign(logic [31:0] raw);
      signed_mag_type r;
      r.neg = raw[31];
      r.mag = raw[31] ? (64'h1_0000_0000 - 64'(raw)) : 64'(raw);
      return r;
   endfunction

   function automatic signed_mag_type flip(signed_mag_type a);
      if (a.mag != 0) a.neg = !a.neg;
      return a;
   endfunction

   function automatic signed_mag_type times(signed_mag_type a, signed_mag_type b);
      signed_mag_type r;
      r.mag = a.mag * b.mag;
      r.neg = (r.mag != 0) && (a.neg != b.neg);
      return r;
   endfunction

   function automatic signed_mag_type plus(signed_mag_type a, signed_mag_type b);
      signed_mag_type r;
      if (a.neg == b.neg) begin
         r.mag = a.mag + b.mag;
         r.neg = a.neg;
      end else if (a.mag >= b.mag) begin
         r.mag = a.mag - b.mag;
         r.neg = a.neg;
      end else begin
         r.mag = b.mag - a.mag;
         r.neg = b.neg;
      end
      if (r.mag == 0) r.neg = 1'b0;
      return r;
   endfunction

   // exact fraction result, reduced, with status and order
   function automatic answer_type reduced_fraction(word_type w);
      answer_type     a;
      signed_mag_type xn, xd, yn, yd, n, d, diff;
      logic [63:0]    g, t, b;
      bit             uses_y;
      a.res_num = '0;
      a.res_den = 31'd1;
      a.order   = ORD_LESS;
      a.status  = ST_OK;
      xn = split_sign(w.x_num);
      xd = split_sign(w.x_den);
      yn = split_sign(w.y_num);
      yd = split_sign(w.y_den);
      uses_y = (w.command <= CMD_DIV) || (w.command == CMD_CMP);
      if (w.command == CMD_NOP) return a;
      if (xd.mag == 0 || (uses_y && yd.mag == 0) ||
          (w.command == CMD_DIV && yn.mag == 0)) begin
         a.res_den = '0;
         a.status  = ST_ZERO_DEN;
         return a;
      end
      if (xd.neg) begin
         xn = flip(xn);
         xd.neg = 1'b0;
      end
      if (uses_y && yd.neg) begin
         yn = flip(yn);
         yd.neg = 1'b0;
      end
      case (w.command)
         CMD_ADD: begin
            n = plus(times(xn, yd), times(yn, xd));
            d = times(xd, yd);
         end
         CMD_SUB: begin
            n = plus(times(xn, yd), flip(times(yn, xd)));
            d = times(xd, yd);
         end
         CMD_MUL: begin
            n = times(xn, yn);
            d = times(xd, yd);
         end
         CMD_DIV: begin
            n = times(xn, yd);
            d = times(xd, yn);
            if (d.neg) begin
               n = flip(n);
               d.neg = 1'b0;
            end
         end
         CMD_NEG: begin
            n = flip(xn);
            d = xd;
         end
         CMD_RED: begin
            n = xn;
            d = xd;
         end
         default: begin
            diff = plus(times(xn, yd), flip(times(yn, xd)));
            a.order = (diff.mag == 0) ? ORD_EQUAL : (diff.neg ? ORD_LESS : ORD_GREATER);
            return a;
         end
      endcase
      // Euclid on the magnitudes
      g = n.mag;
      b = d.mag;
      while (b != 0) begin
         t = g % b;
         g = b;
         b = t;
      end
      n.mag = n.mag / g;
      d.mag = d.mag / g;
      if (n.mag == 0) n.neg = 1'b0;
      if ((n.neg ? n.mag > 64'h8000_0000 : n.mag > 64'h7FFF_FFFF) ||
          d.mag > 64'h7FFF_FFFF) begin
         a.status  = ST_OVERFLOW;
         a.res_den = '0;
      end else begin
         a.res_num = n.neg ? 32'(-n.mag) : n.mag[31:0];
         a.res_den = d.mag[30:0];
      end
      return a;
   endfunction

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'(int'($urandom_range(0, 2)) - 1);
         3, 4, 5: return 32'(int'($urandom_range(0, 200)) - 100);
         6, 7: return 32'(int'($urandom_range(0, 200000)) - 100000);
         default: return $urandom;
      endcase
   endfunction

   function automatic int rand_gap();
      if ($urandom_range(0, 3) != 0) return 0;
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // driver: raises start while a word is pending and holds it until the unit takes it
   always @(posedge clock) begin
      word_type w;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         // current word taken this edge
         words_sent++;
         expected_answers.push_back(reduced_fraction('{cmd_type'(req_command),
            req_x_num, req_x_den, req_y_num, req_y_den}));
         gap_left = rand_gap();
         if (gap_left == 0 && pending_words.size() > 0) begin
            w = pending_words.pop_front();
            req_command <= w.command;
            req_x_num <= w.x_num;
            req_x_den <= w.x_den;
            req_y_num <= w.y_num;
            req_y_den <= w.y_den;
         end else begin
            start <= 1'b0;
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            start <= 1'b1;
            req_command <= w.command;
            req_x_num <= w.x_num;
            req_x_den <= w.x_den;
            req_y_num <= w.y_num;
            req_y_den <= w.y_den;
         end
      end
   end

   // monitor: every strobe is compared against the oldest expectation
   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid) begin
         answers_seen++;
         if (expected_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word num=%h", rsp_res_num);
         end else begin
            e = expected_answers.pop_front();
            if (rsp_res_num !== e.res_num || rsp_res_den !== e.res_den ||
                rsp_order !== e.order || rsp_status !== e.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp num=%h den=%h ord=%0d st=%0d %s",
                     e.res_num, e.res_den, e.order, e.status,
                     $sformatf("got num=%h den=%h ord=%0d st=%0d",
                        rsp_res_num, rsp_res_den, rsp_order, rsp_status));
            end
         end
      end
   end

   function automatic void queue_word(cmd_type c, logic [31:0] xn, logic [31:0] xd,
                                      logic [31:0] yn, logic [31:0] yd);
      pending_words.push_back('{c, xn, xd, yn, yd});
   endfunction

   initial begin
      word_type w;
      int       k;
      // directed corners
      queue_word(CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
      queue_word(CMD_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
      queue_word(CMD_MUL, -32'sd3, 32'd4, 32'd8, -32'sd9);
      queue_word(CMD_DIV, 32'd5, 32'd7, 32'd0, 32'd3);
      queue_word(CMD_DIV, 32'd5, -32'sd7, -32'sd10, 32'd3);
      queue_word(CMD_NEG, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
      queue_word(CMD_NEG, 32'h8000_0000, 32'hFFFF_FFFF, 32'd9, 32'd0);
      queue_word(CMD_RED, 32'd0, 32'h8000_0000, 32'd0, 32'd0);
      queue_word(CMD_RED, 32'd6, 32'h8000_0000, 32'd0, 32'd0);
      queue_word(CMD_RED, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0);
      queue_word(CMD_RED, 32'd12, 32'd0, 32'd1, 32'd1);
      queue_word(CMD_ADD, 32'd1, 32'd1, 32'd1, 32'd0);
      queue_word(CMD_CMP, 32'd1, 32'd2, 32'd2, 32'd4);
      queue_word(CMD_CMP, 32'd1, -32'sd2, 32'd0, 32'd4);
      queue_word(CMD_CMP, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'd1);
      queue_word(CMD_CMP, 32'h7FFF_FFFF, 32'd1, 32'h8000_0000, 32'h8000_0000);
      queue_word(CMD_CMP, 32'd3, 32'd0, 32'd1, 32'd1);
      queue_word(CMD_MUL, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
      queue_word(CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'd1, 32'h7FFF_FFFD);
      queue_word(CMD_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
      queue_word(CMD_NOP, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0);
      queue_word(CMD_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // random words
      for (k = 0; k < 880; k++) begin
         w.command = cmd_type'($urandom_range(0, 7));
         w.x_num = rand_operand();
         w.x_den = rand_operand();
         w.y_num = rand_operand();
         w.y_den = rand_operand();
         if ($urandom_range(0, 19) == 0) w.x_den = '0;
         if ($urandom_range(0, 19) == 0) w.y_num = '0;
         pending_words.push_back(w);
      end
      words_total = pending_words.size();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (words_sent < words_total) @(posedge clock);
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d words (all commands, zero denominators, width extremes)",
         words_sent);
      $display("%0d results checked, %0d mismatches", answers_seen, mismatches);
      if (mismatches == 0 && expected_answers.size() == 0 && answers_seen == words_sent)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

   // watchdog: stops a hung run and reports a failure
   initial begin
      #60000000;
      $display("tb failed");
      $finish;
   end

endmodule
